@@ rtl/lobm_pkg.sv @@
// Package with the word types, result codes and action codes of the order book matcher.
package lobm_pkg;

  localparam logic [1:0] ACT_LIMIT  = 2'd0;
  localparam logic [1:0] ACT_MARKET = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] RK_TRADE   = 3'd0;
  localparam logic [2:0] RK_RESTED  = 3'd1;
  localparam logic [2:0] RK_DONE    = 3'd2;
  localparam logic [2:0] RK_BADTICK = 3'd3;
  localparam logic [2:0] RK_FULL    = 3'd4;
  localparam logic [2:0] RK_CANCEL  = 3'd5;
  localparam logic [2:0] RK_MISS    = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] order_id;
    logic [31:0] owner_id;
    logic        side;
    logic [7:0]  price_tick;
    logic [31:0] quantity;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [63:0] buyer_order_id;
    logic [63:0] seller_order_id;
    logic [7:0]  trade_tick;
    logic [31:0] trade_quantity;
    logic [31:0] remaining_quantity;
    logic        last;
  } res_t;

  // One resting order as held in the slot memory.
  typedef struct packed {
    logic [63:0] order_id;
    logic [31:0] trader;
    logic        side;
    logic [7:0]  tick;
    logic [31:0] quantity;
    logic [31:0] arrival;
  } slot_t;

endpackage

@@ rtl/lobm_slot_mem.sv @@
// Slot memory holding the resting orders, one write and one registered read port.
module lobm_slot_mem
  import lobm_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output slot_t         rd_data
);

  slot_t mem [DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/limit_order_book_matcher.sv @@
// Top level of the order book matcher: sequencer, valid bits and slot memory.
//
//  channel | ports                         | handshake
//  request | start, busy, in_req           | taken when start and not busy
//  result  | out_strobe, out_res           | one word per strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_data| taken when valid and ready
//
// A bad tick or an unused action is answered in the cycle after it is taken. A
// cancel walks the one read port of the slot memory an entry a cycle. An order
// scans the slot memory once per trade, up to MAX_ORDERS trades, then once
// more to find no match unless it is filled or at that cap, and sends its
// closing word. Reset is synchronous and clears the valid bits, so no clearing
// pass is needed. Results cannot be stalled.
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int NUM_TICKS  = 256,
  parameter int MAX_ORDERS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  req_t       in_req,
  output logic       out_strobe,
  output res_t       out_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CW = AW + 1;
  localparam logic [7:0] TOP_TICK = (NUM_TICKS > 256) ? 8'hFF : 8'(NUM_TICKS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]            state_r, state_nxt;
  logic [7:0]            max_tick_r;
  logic [MAX_ORDERS-1:0] valid_r;
  logic [31:0]           arrival_r;
  req_t                  req_r;
  logic [31:0]           rem_r;
  logic [7:0]            limit_r;
  logic [CW-1:0]         rd_cnt_r;   // address issued
  logic [CW-1:0]         chk_cnt_r;  // address whose data is now out
  logic                  chk_r;
  logic                  found_r;
  logic [AW-1:0]         best_idx_r;
  slot_t                 best_r;
  logic [5:0]            ntrades_r;

  logic [7:0] bound;
  assign bound = (max_tick_r > TOP_TICK) ? TOP_TICK : max_tick_r;

  // Memory ports.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data;
  slot_t         rd_data;

  lobm_slot_mem #(.DEPTH(MAX_ORDERS), .AW(AW)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_cnt_r[AW-1:0]),
    .rd_data(rd_data)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  // Candidate test on the word read out of the memory.
  logic [AW-1:0] chk_idx;
  logic          cand_ok, cand_better, hit_cancel;
  logic [31:0]   age_c, age_b;
  assign chk_idx = chk_cnt_r[AW-1:0];
  assign age_c   = arrival_r - rd_data.arrival;
  assign age_b   = arrival_r - best_r.arrival;

  always_comb begin
    cand_ok = valid_r[chk_idx] && (rd_data.side != req_r.side) &&
              (rd_data.trader != req_r.owner_id);
    if (!req_r.side) begin
      cand_ok = cand_ok && (rd_data.tick <= limit_r) && (rd_data.tick <= bound);
    end else begin
      cand_ok = cand_ok && (rd_data.tick >= limit_r);
    end
    if (!found_r) begin
      cand_better = 1'b1;
    end else if (rd_data.tick != best_r.tick) begin
      cand_better = req_r.side ? (rd_data.tick > best_r.tick) : (rd_data.tick < best_r.tick);
    end else begin
      cand_better = age_c > age_b;
    end
    hit_cancel = valid_r[chk_idx] && (rd_data.order_id == req_r.order_id);
  end

  // Lowest free slot, found from the valid bits.
  logic          free_any;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic [31:0] traded, best_left;
  assign traded    = (rem_r < best_r.quantity) ? rem_r : best_r.quantity;
  assign best_left = best_r.quantity - traded;

  // A trade is made only while some quantity is still wanted.
  logic fill_go;
  assign fill_go = found_r && (rem_r != '0);

  logic scan_end;
  assign scan_end = chk_r && (chk_cnt_r == CW'(MAX_ORDERS - 1));

  // Unused actions and bad ticks go straight to the closing word.
  logic quick;
  assign quick = (in_req.action == ACT_UNUSED) ||
                 ((in_req.action == ACT_LIMIT) && (in_req.price_tick > bound));

  // Quick path flags: the closing word then reports done or bad tick.
  logic quick_r;
  logic quick_bad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quick_r     <= 1'b0;
      quick_bad_r <= 1'b0;
    end else if (state_r == ST_IDLE) begin
      quick_r     <= start && quick;
      quick_bad_r <= in_req.action != ACT_UNUSED;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    wr_en      = 1'b0;
    wr_addr    = best_idx_r;
    wr_data    = best_r;
    out_strobe = 1'b0;
    out_res    = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = quick ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (req_r.action == ACT_CANCEL && chk_r && hit_cancel) begin
          out_strobe          = 1'b1;
          out_res.result_kind = RK_CANCEL;
          out_res.last        = 1'b1;
          state_nxt           = ST_IDLE;
        end else if (scan_end) begin
          if (req_r.action == ACT_CANCEL) begin
            out_strobe          = 1'b1;
            out_res.result_kind = RK_MISS;
            out_res.last        = 1'b1;
            state_nxt           = ST_IDLE;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (fill_go) begin
          wr_en                      = 1'b1;
          wr_data.quantity           = best_left;
          out_strobe                 = 1'b1;
          out_res.result_kind        = RK_TRADE;
          out_res.buyer_order_id     = req_r.side ? best_r.order_id : req_r.order_id;
          out_res.seller_order_id    = req_r.side ? req_r.order_id : best_r.order_id;
          out_res.trade_tick         = best_r.tick;
          out_res.trade_quantity     = traded;
          out_res.remaining_quantity = rem_r - traded;
          if ((rem_r == traded) || (ntrades_r == 6'(MAX_ORDERS - 1))) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_strobe                 = 1'b1;
        out_res.last               = 1'b1;
        out_res.remaining_quantity = rem_r;
        if (quick_r) begin
          out_res.result_kind = quick_bad_r ? RK_BADTICK : RK_DONE;
        end else if (req_r.action == ACT_MARKET || rem_r == '0) begin
          out_res.result_kind = RK_DONE;
        end else if (!free_any) begin
          out_res.result_kind = RK_FULL;
        end else begin
          out_res.result_kind = RK_RESTED;
          wr_en               = 1'b1;
          wr_addr             = free_idx;
          wr_data.order_id    = req_r.order_id;
          wr_data.trader      = req_r.owner_id;
          wr_data.side        = req_r.side;
          wr_data.tick        = req_r.price_tick;
          wr_data.quantity    = rem_r;
          wr_data.arrival     = arrival_r;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      max_tick_r <= 8'hFF;
      valid_r    <= '0;
      arrival_r  <= '0;
      rd_cnt_r   <= '0;
      chk_cnt_r  <= '0;
      chk_r      <= 1'b0;
      found_r    <= 1'b0;
      ntrades_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        max_tick_r <= cfg_data;
      end
      case (state_r)
        ST_IDLE: begin
          rd_cnt_r  <= '0;
          chk_r     <= 1'b0;
          found_r   <= 1'b0;
          ntrades_r <= '0;
        end
        ST_SCAN: begin
          if (rd_cnt_r != CW'(MAX_ORDERS)) begin
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end
          chk_cnt_r <= rd_cnt_r;
          chk_r     <= (rd_cnt_r != CW'(MAX_ORDERS));
          if (chk_r && req_r.action == ACT_CANCEL && hit_cancel) begin
            valid_r[chk_idx] <= 1'b0;
          end
          if (chk_r && req_r.action != ACT_CANCEL && cand_ok && cand_better) begin
            found_r <= 1'b1;
          end
        end
        ST_FILL: begin
          rd_cnt_r  <= '0;
          chk_r     <= 1'b0;
          found_r   <= 1'b0;
          ntrades_r <= ntrades_r + 1'b1;
          if (fill_go) begin
            if (best_left == '0) begin
              valid_r[best_idx_r] <= 1'b0;
            end
          end
        end
        ST_DONE: begin
          if (wr_en) begin
            valid_r[free_idx] <= 1'b1;
            arrival_r         <= arrival_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      req_r   <= in_req;
      rem_r   <= in_req.quantity;
      limit_r <= (in_req.action == ACT_MARKET) ? (in_req.side ? 8'd0 : bound)
                                               : in_req.price_tick;
    end
    if (state_r == ST_SCAN && chk_r && cand_ok && cand_better) begin
      best_r     <= rd_data;
      best_idx_r <= chk_idx;
    end
    if (state_r == ST_FILL && fill_go) begin
      rem_r <= rem_r - traded;
    end
  end

`ifndef NO_ASSERTIONS
  // A result word never appears while idle.
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !out_strobe) else $error("result while idle");
  // Every word marked last returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.last) |=> (state_r == ST_IDLE)) else $error("last not closing");
  // A trade always moves a nonzero quantity.
  a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.result_kind == RK_TRADE) |-> (out_res.trade_quantity != '0))
    else $error("empty trade");
`endif

endmodule
